// File: src/byte_change_heatmap_macros.svh
// ---------------------------------------------------------------------------
// byte_change_heatmap assertion macros
// shared property shapes for the checker
// ---------------------------------------------------------------------------
`ifndef BYTE_CHANGE_HEATMAP_MACROS_SVH
`define BYTE_CHANGE_HEATMAP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BCH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bch_pkg.sv
// ---------------------------------------------------------------------------
// bch_pkg
// shared widths, codes and types of the byte change heatmap
// ---------------------------------------------------------------------------
package bch_pkg;

   // payload widths
   localparam int DATA_W     = 8;
   localparam int COUNT_W    = 16;
   localparam int QIDX_W     = 5;
   localparam int CLASS_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_FRAMES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARM_FROM     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_FROM      = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] BUCKET_FRAMES_RST = 16'd5000;
   localparam logic [CSR_DATA_W-1:0] WARM_FROM_RST     = 16'd50;
   localparam logic [CSR_DATA_W-1:0] HOT_FROM_RST      = 16'd2500;

   // request opcodes
   localparam logic OP_FEED  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // saturation value of a counter
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [CLASS_W-1:0] {
      HEAT_COLD = 2'd0,
      HEAT_WARM = 2'd1,
      HEAT_HOT  = 2'd2
   } heat_type;

   // configuration register set
   typedef struct packed {
      logic [CSR_DATA_W-1:0] bucket_frames;
      logic [CSR_DATA_W-1:0] warm_from;
      logic [CSR_DATA_W-1:0] hot_from;
   } csr_type;

   // request info handed from the tracker to the update stage
   typedef struct packed {
      logic              feed;
      logic              query;
      logic              compare;
      logic              in_range;
      logic              full;
      logic [QIDX_W-1:0] bucket;
      logic [DATA_W-1:0] data_byte;
   } stage_type;

endpackage

// File: src/bch_req_if.sv
// ---------------------------------------------------------------------------
// bch_req_if
// request channel: stream byte or counter query
// ---------------------------------------------------------------------------
interface bch_req_if;
   import bch_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [DATA_W-1:0] data_byte;
   logic [QIDX_W-1:0] query_bucket;
   logic [QIDX_W-1:0] query_column;

   modport source (output valid, op, data_byte, query_bucket, query_column, input ready);
   modport sink   (input valid, op, data_byte, query_bucket, query_column, output ready);
endinterface

// File: src/bch_rsp_if.sv
// ---------------------------------------------------------------------------
// bch_rsp_if
// response channel: queried counter and its class
// ---------------------------------------------------------------------------
interface bch_rsp_if;
   import bch_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] change_count;
   logic [CLASS_W-1:0] heat_class;
   logic               buckets_full;
   logic [QIDX_W-1:0]  current_bucket;

   modport source (output valid, change_count, heat_class, buckets_full, current_bucket,
                   input ready);
   modport sink   (input valid, change_count, heat_class, buckets_full, current_bucket,
                   output ready);
endinterface

// File: src/bch_ram.sv
// ---------------------------------------------------------------------------
// bch_ram
// simple dual-port ram, one write and one registered read, read-first
// ---------------------------------------------------------------------------
module bch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/bch_tracker.sv
// ---------------------------------------------------------------------------
// bch_tracker
// frame position and bucket tracking, ram read issue, counter clear sweep
// ---------------------------------------------------------------------------
module bch_tracker #(
   parameter int FRAME_BYTES = 26,
   parameter int BUCKETS     = 20
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   accept,
   input  logic                                                   op,
   input  logic [bch_pkg::DATA_W-1:0]                             data_byte,
   input  logic [bch_pkg::QIDX_W-1:0]                             query_bucket,
   input  logic [bch_pkg::QIDX_W-1:0]                             query_column,
   input  bch_pkg::csr_type                                       csr,
   output logic                                                   prev_we,
   output logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] prev_addr,
   output logic [((BUCKETS * FRAME_BYTES > 1) ?
                  $clog2(BUCKETS * FRAME_BYTES) : 1)-1:0]          cnt_rd_addr,
   output bch_pkg::stage_type                                     stage,
   output logic                                                   clearing,
   output logic [((BUCKETS * FRAME_BYTES > 1) ?
                  $clog2(BUCKETS * FRAME_BYTES) : 1)-1:0]          clear_addr
);
   import bch_pkg::*;

   localparam int POS_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int CNT_DEPTH = BUCKETS * FRAME_BYTES;
   localparam int CNT_AW    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
   localparam int BKT_W     = $clog2(BUCKETS + 1);

   localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(FRAME_BYTES - 1);
   localparam logic [BKT_W-1:0]  FULL_BKT   = BKT_W'(BUCKETS);
   localparam logic [CNT_AW-1:0] LAST_ENTRY = CNT_AW'(CNT_DEPTH - 1);
   localparam logic [CNT_AW-1:0] ROW_STEP   = CNT_AW'(FRAME_BYTES);

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CSR_DATA_W-1:0] frames_ff, frames_in;
   logic [BKT_W-1:0]      bucket_ff, bucket_in;
   logic [CNT_AW-1:0]     base_ff, base_in;
   logic                  first_ff, first_in;
   logic                  clear_ff, clear_in;
   logic [CNT_AW-1:0]     clear_addr_ff, clear_addr_in;

   logic                  full;
   logic                  feed_go;
   logic [CSR_DATA_W:0]   frames_next;
   logic [CNT_AW-1:0]     query_idx;

   // request decode
   assign full    = (bucket_ff == FULL_BKT);
   assign feed_go = accept && (op == OP_FEED) && !full;

   // previous-frame ram: read and overwrite the same position, read-first
   assign prev_we   = feed_go;
   assign prev_addr = pos_ff;

   // counter ram read address: running row base for feeds, row times width for queries
   assign query_idx   = CNT_AW'(32'(query_bucket) * FRAME_BYTES + 32'(query_column));
   assign cnt_rd_addr = (op == OP_FEED) ? (base_ff + CNT_AW'(pos_ff)) : query_idx;

   // request info for the update stage
   always_comb begin
      stage.feed      = feed_go;
      stage.query     = accept && (op == OP_QUERY);
      stage.compare   = !first_ff;
      stage.in_range  = (32'(query_bucket) < BUCKETS) && (32'(query_column) < FRAME_BYTES);
      stage.full      = full;
      stage.bucket    = QIDX_W'(bucket_ff);
      stage.data_byte = data_byte;
   end

   assign clearing   = clear_ff;
   assign clear_addr = clear_addr_ff;

   // next position, frame and bucket
   always_comb begin
      pos_in        = pos_ff;
      frames_in     = frames_ff;
      bucket_in     = bucket_ff;
      base_in       = base_ff;
      first_in      = first_ff;
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      frames_next   = {1'b0, frames_ff} + (CSR_DATA_W + 1)'(1);

      if (feed_go) begin
         if (pos_ff == LAST_POS) begin
            pos_in   = '0;
            first_in = 1'b0;
            // a zero frame count closes a bucket after every frame
            if (frames_next >= {1'b0, csr.bucket_frames}) begin
               frames_in = '0;
               bucket_in = bucket_ff + BKT_W'(1);
               base_in   = base_ff + ROW_STEP;
            end else begin
               frames_in = frames_next[CSR_DATA_W-1:0];
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end

      // clear sweep after reset, one counter per cycle
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + CNT_AW'(1);
         if (clear_addr_ff == LAST_ENTRY) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         frames_ff     <= '0;
         bucket_ff     <= '0;
         base_ff       <= '0;
         first_ff      <= 1'b1;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         pos_ff        <= pos_in;
         frames_ff     <= frames_in;
         bucket_ff     <= bucket_in;
         base_ff       <= base_in;
         first_ff      <= first_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end
endmodule

// File: src/bch_update.sv
// ---------------------------------------------------------------------------
// bch_update
// counter read-modify-write with forwarding, classification, response register
// ---------------------------------------------------------------------------
module bch_update #(
   parameter int CNT_AW = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  bch_pkg::stage_type           stage,
   input  logic [CNT_AW-1:0]            addr,
   input  logic [bch_pkg::DATA_W-1:0]   prev_rdata,
   input  logic [bch_pkg::COUNT_W-1:0]  cnt_rdata,
   input  bch_pkg::csr_type             csr,
   input  logic                         clearing,
   input  logic [CNT_AW-1:0]            clear_addr,
   output logic                         cnt_we,
   output logic [CNT_AW-1:0]            cnt_wr_addr,
   output logic [bch_pkg::COUNT_W-1:0]  cnt_wr_data,
   output logic                         stage_free,
   bch_rsp_if.source                    rsp
);
   import bch_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   stage_type          s1_ff;
   logic [CNT_AW-1:0]  s1_addr_ff;

   logic               fwd_valid_ff;
   logic [CNT_AW-1:0]  fwd_addr_ff;
   logic [COUNT_W-1:0] fwd_data_ff;

   logic               out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0] out_count_ff;
   heat_type           out_class_ff;
   logic               out_full_ff;
   logic [QIDX_W-1:0]  out_bucket_ff;

   logic [COUNT_W-1:0] cur_count;
   logic               bump;
   logic               s1_advance;
   logic [COUNT_W-1:0] rsp_count;
   heat_type           rsp_class;

   // counter value, bypassing the write made at the edge of this read
   assign cur_count = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : cnt_rdata;

   // a changed byte bumps the counter, saturating
   assign bump = s1_valid_ff && s1_ff.feed && s1_ff.compare &&
                 (prev_rdata != s1_ff.data_byte) && (cur_count != COUNT_MAX);

   // counter write port: clear sweep or increment
   always_comb begin
      if (clearing) begin
         cnt_we      = 1'b1;
         cnt_wr_addr = clear_addr;
         cnt_wr_data = '0;
      end else begin
         cnt_we      = bump;
         cnt_wr_addr = s1_addr_ff;
         cnt_wr_data = cur_count + COUNT_W'(1);
      end
   end

   // stage advance: a query needs room in the response register
   assign s1_advance  = s1_valid_ff && (!s1_ff.query || !out_valid_ff || rsp.ready);
   assign stage_free  = !s1_valid_ff || s1_advance;
   assign s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   // classification, out-of-range cells read as cold zero
   always_comb begin
      rsp_count = s1_ff.in_range ? cur_count : '0;
      rsp_class = HEAT_COLD;
      if (s1_ff.in_range) begin
         if (cur_count < csr.warm_from) begin
            rsp_class = HEAT_COLD;
         end else if (cur_count < csr.hot_from) begin
            rsp_class = HEAT_WARM;
         end else begin
            rsp_class = HEAT_HOT;
         end
      end
   end

   assign out_valid_in = (s1_advance && s1_ff.query) ? 1'b1 :
                         (rsp.ready ? 1'b0 : out_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            fwd_valid_ff <= cnt_we;
         end
      end
   end

   // stage, bypass and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= stage;
         s1_addr_ff  <= addr;
         fwd_addr_ff <= cnt_wr_addr;
         fwd_data_ff <= cnt_wr_data;
      end
      if (s1_advance && s1_ff.query) begin
         out_count_ff  <= rsp_count;
         out_class_ff  <= rsp_class;
         out_full_ff   <= s1_ff.full;
         out_bucket_ff <= s1_ff.bucket;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.change_count   = out_count_ff;
   assign rsp.heat_class     = out_class_ff;
   assign rsp.buckets_full   = out_full_ff;
   assign rsp.current_bucket = out_bucket_ff;
endmodule

// File: src/byte_change_heatmap.sv
// ---------------------------------------------------------------------------
// byte_change_heatmap
// per-position byte change counters over bucketed frames, with counter query
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  req_bus   in         op, data_byte, query_bucket, query_column
//  rsp_bus   out        change_count, heat_class, buckets_full, current_bucket
//  csr_*     in         csr_we, csr_index, csr_wdata (write only)
//
//  one request per cycle while req ready is high; a query response is registered, the query
//  moving from the stage register into the response register once that has room
//  the counter ram is read at acceptance and written back in the cycle after, the
//  write of the same edge is bypassed
//  after reset a clear pass over all BUCKETS*FRAME_BYTES counters (520) holds req ready low
//  a query held by a full response register keeps req ready low until it moves on
// ---------------------------------------------------------------------------
module byte_change_heatmap #(
   parameter int FRAME_BYTES = 26,
   parameter int BUCKETS     = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   bch_req_if.sink                           req_bus,
   bch_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [bch_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bch_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bch_pkg::*;

   localparam int POS_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int CNT_DEPTH = BUCKETS * FRAME_BYTES;
   localparam int CNT_AW    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

   csr_type            csr_ff, csr_in;
   logic               accept;
   logic               prev_we;
   logic [POS_W-1:0]   prev_addr;
   logic [DATA_W-1:0]  prev_rdata;
   logic [CNT_AW-1:0]  cnt_rd_addr;
   logic [COUNT_W-1:0] cnt_rdata;
   logic               cnt_we;
   logic [CNT_AW-1:0]  cnt_wr_addr;
   logic [COUNT_W-1:0] cnt_wr_data;
   stage_type          stage;
   logic               clearing;
   logic [CNT_AW-1:0]  clear_addr;
   logic               stage_free;

   // configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BUCKET_FRAMES: csr_in.bucket_frames = csr_wdata;
            CSR_WARM_FROM:     csr_in.warm_from     = csr_wdata;
            CSR_HOT_FROM:      csr_in.hot_from      = csr_wdata;
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.bucket_frames <= BUCKET_FRAMES_RST;
         csr_ff.warm_from     <= WARM_FROM_RST;
         csr_ff.hot_from      <= HOT_FROM_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // request handshake
   assign req_bus.ready = !clearing && stage_free;
   assign accept        = req_bus.valid && req_bus.ready;

   bch_tracker #(
      .FRAME_BYTES (FRAME_BYTES),
      .BUCKETS     (BUCKETS)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .op           (req_bus.op),
      .data_byte    (req_bus.data_byte),
      .query_bucket (req_bus.query_bucket),
      .query_column (req_bus.query_column),
      .csr          (csr_ff),
      .prev_we      (prev_we),
      .prev_addr    (prev_addr),
      .cnt_rd_addr  (cnt_rd_addr),
      .stage        (stage),
      .clearing     (clearing),
      .clear_addr   (clear_addr)
   );

   // previous frame bytes
   bch_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FRAME_BYTES)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_addr),
      .wr_data (req_bus.data_byte),
      .rd_en   (accept),
      .rd_addr (prev_addr),
      .rd_data (prev_rdata)
   );

   // change counters, one row per bucket
   bch_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (CNT_DEPTH)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (accept),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rdata)
   );

   bch_update #(
      .CNT_AW (CNT_AW)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stage       (stage),
      .addr        (cnt_rd_addr),
      .prev_rdata  (prev_rdata),
      .cnt_rdata   (cnt_rdata),
      .csr         (csr_ff),
      .clearing    (clearing),
      .clear_addr  (clear_addr),
      .cnt_we      (cnt_we),
      .cnt_wr_addr (cnt_wr_addr),
      .cnt_wr_data (cnt_wr_data),
      .stage_free  (stage_free),
      .rsp         (rsp_bus)
   );
endmodule

// File: src/bch_checker.sv
// ---------------------------------------------------------------------------
// bch_checker
// port-level checks of the byte change heatmap, bound to the top level
// ---------------------------------------------------------------------------
`include "byte_change_heatmap_macros.svh"

module bch_checker #(
   parameter int BUCKETS = 20
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_op,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bch_pkg::COUNT_W-1:0]    rsp_change_count,
   input logic                           rsp_buckets_full,
   input logic [bch_pkg::QIDX_W-1:0]     rsp_current_bucket
);
   import bch_pkg::*;

   localparam logic [QIDX_W-1:0] FULL_CODE = QIDX_W'(BUCKETS);

   // a stalled response holds
   `BCH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_change_count), "stalled response changed")

   // full flag and bucket number agree
   `BCH_ASSERT_NOW(a_full_bucket, clock, reset, rsp_valid && rsp_buckets_full, rsp_current_bucket == FULL_CODE, "full without last bucket")

   // a fresh response comes from an accepted query
   `BCH_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && (req_op == OP_QUERY), 2), "response without query")

   // counter clear keeps requests out after reset
   `BCH_ASSERT_NOW(a_clear_block, clock, reset, $fell(reset), !req_ready, "request taken during counter clear")
endmodule

bind byte_change_heatmap bch_checker #(
   .BUCKETS (BUCKETS)
) u_bch_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_op             (req_bus.op),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_change_count   (rsp_bus.change_count),
   .rsp_buckets_full   (rsp_bus.buckets_full),
   .rsp_current_bucket (rsp_bus.current_bucket)
);

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for byte_change_heatmap: a shadow of the frame tracker
// and counter store predicts every query response, under random stalls on
// both channels and several register settings
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bch_pkg::*;

   localparam int FRAME_BYTES   = 26;
   localparam int BUCKETS       = 20;
   localparam int CELLS         = FRAME_BYTES * BUCKETS;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      logic              op;
      logic [DATA_W-1:0] data_byte;
      logic [QIDX_W-1:0] query_bucket;
      logic [QIDX_W-1:0] query_column;
      bit                wait_for_replies;
   } heat_request_t;

   typedef struct {
      logic [COUNT_W-1:0] change_count;
      heat_type           heat_class;
      logic               buckets_full;
      logic [QIDX_W-1:0]  current_bucket;
   } heat_reply_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bch_req_if req_bus ();
   bch_rsp_if rsp_bus ();

   byte_change_heatmap #(
      .FRAME_BYTES (FRAME_BYTES),
      .BUCKETS     (BUCKETS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // requests waiting to be driven and responses still owed
   heat_request_t request_queue[$];
   heat_reply_t   predicted_replies[$];
   int            pending_replies;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int feeds_taken;
   int replies_checked;
   int settings_written;
   int idle_cycles;

   // shadow of the block's settings and state
   logic [CSR_DATA_W-1:0] frames_per_bucket;
   logic [CSR_DATA_W-1:0] warm_level;
   logic [CSR_DATA_W-1:0] hot_level;
   logic [DATA_W-1:0]     prior_frame [FRAME_BYTES];
   logic [COUNT_W-1:0]    cell_count  [CELLS];
   int                    frame_pos;
   int                    frames_done;
   int                    fill_bucket;
   bit                    opening_frame;

   // last byte queued at each frame position, for shaping the stream
   logic [DATA_W-1:0] stream_shadow [FRAME_BYTES];
   int                stream_pos;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // advance the shadow by one accepted request, queue the response it owes
   function automatic void advance_heatmap(input heat_request_t r);
      heat_reply_t reply;
      int          slot;
      if (r.op == OP_FEED) begin
         if (fill_bucket < BUCKETS) begin
            slot = fill_bucket * FRAME_BYTES + frame_pos;
            if (!opening_frame && prior_frame[frame_pos] != r.data_byte &&
                cell_count[slot] != COUNT_MAX) begin
               cell_count[slot] = cell_count[slot] + 1'b1;
            end
            prior_frame[frame_pos] = r.data_byte;
            frame_pos++;
            if (frame_pos == FRAME_BYTES) begin
               frame_pos     = 0;
               opening_frame = 1'b0;
               frames_done++;
               // zero frames per bucket behaves as one
               if (frames_done >= frames_per_bucket) begin
                  frames_done = 0;
                  fill_bucket++;
               end
            end
         end
      end else begin
         reply.change_count = '0;
         reply.heat_class   = HEAT_COLD;
         if (r.query_bucket < BUCKETS && r.query_column < FRAME_BYTES) begin
            reply.change_count = cell_count[r.query_bucket * FRAME_BYTES + r.query_column];
            // cold test first, so reversed thresholds leave low counts cold
            if (reply.change_count < warm_level) begin
               reply.heat_class = HEAT_COLD;
            end else if (reply.change_count < hot_level) begin
               reply.heat_class = HEAT_WARM;
            end else begin
               reply.heat_class = HEAT_HOT;
            end
         end
         reply.buckets_full   = (fill_bucket >= BUCKETS);
         reply.current_bucket = QIDX_W'(fill_bucket);
         predicted_replies.push_back(reply);
      end
   endfunction

   // monitor: register writes, accepted requests, checked responses
   always @(posedge clock) begin
      heat_request_t taken;
      heat_reply_t   want;
      if (reset) begin
         frames_per_bucket = BUCKET_FRAMES_RST;
         warm_level        = WARM_FROM_RST;
         hot_level         = HOT_FROM_RST;
         for (int i = 0; i < FRAME_BYTES; i++) prior_frame[i] = '0;
         for (int i = 0; i < CELLS; i++) cell_count[i] = '0;
         frame_pos     = 0;
         frames_done   = 0;
         fill_bucket   = 0;
         opening_frame = 1'b1;
         predicted_replies.delete();
         pending_replies <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BUCKET_FRAMES: frames_per_bucket = csr_wdata;
               CSR_WARM_FROM:     warm_level        = csr_wdata;
               CSR_HOT_FROM:      hot_level         = csr_wdata;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.op               = req_bus.op;
            taken.data_byte        = req_bus.data_byte;
            taken.query_bucket     = req_bus.query_bucket;
            taken.query_column     = req_bus.query_column;
            taken.wait_for_replies = 1'b0;
            if (taken.op == OP_FEED) feeds_taken++;
            advance_heatmap(taken);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_replies.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("%0t: response with none outstanding: count %0d class %0d",
                           $realtime, rsp_bus.change_count, rsp_bus.heat_class);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               replies_checked++;
               if (rsp_bus.change_count !== want.change_count ||
                   rsp_bus.heat_class !== want.heat_class ||
                   rsp_bus.buckets_full !== want.buckets_full ||
                   rsp_bus.current_bucket !== want.current_bucket) begin
                  if (fail_count < REPORT_MAX) begin
                     $write("%0t: mismatch (expected/actual) count %0d/%0d class %0d/%0d",
                            $realtime, want.change_count, rsp_bus.change_count,
                            want.heat_class, rsp_bus.heat_class);
                     $display(" full %0b/%0b bucket %0d/%0d",
                              want.buckets_full, rsp_bus.buckets_full,
                              want.current_bucket, rsp_bus.current_bucket);
                  end
                  fail_count++;
               end
            end
         end
         pending_replies <= predicted_replies.size();
      end
   end

   // driver: next request from the queue, held until accepted
   always @(posedge clock) begin
      heat_request_t head;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (request_queue.size() != 0 &&
             !(request_queue[0].wait_for_replies && (req_bus.valid || pending_replies != 0)) &&
             $urandom_range(99) >= send_idle_pct) begin
            head = request_queue.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.op           <= head.op;
            req_bus.data_byte    <= head.data_byte;
            req_bus.query_bucket <= head.query_bucket;
            req_bus.query_column <= head.query_column;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic void queue_feed(input logic [DATA_W-1:0] value);
      heat_request_t r;
      r.op               = OP_FEED;
      r.data_byte        = value;
      r.query_bucket     = QIDX_W'($urandom);
      r.query_column     = QIDX_W'($urandom);
      r.wait_for_replies = 1'b0;
      request_queue.push_back(r);
      stream_shadow[stream_pos] = value;
      stream_pos = (stream_pos + 1) % FRAME_BYTES;
   endfunction

   function automatic void queue_query(input int bucket, input int column, input bit hold);
      heat_request_t r;
      r.op               = OP_QUERY;
      r.data_byte        = DATA_W'($urandom);
      r.query_bucket     = QIDX_W'(bucket);
      r.query_column     = QIDX_W'(column);
      r.wait_for_replies = hold;
      request_queue.push_back(r);
   endfunction

   // mostly in-range cells, one in eight out of range per field
   function automatic void queue_random_query(input bit hold);
      int bucket;
      int column;
      bucket = ($urandom_range(7) == 0) ? $urandom_range(31, BUCKETS)
                                        : $urandom_range(BUCKETS - 1);
      column = ($urandom_range(7) == 0) ? $urandom_range(31, FRAME_BYTES)
                                        : $urandom_range(FRAME_BYTES - 1);
      queue_query(bucket, column, hold);
   endfunction

   // whole frames, each byte repeating its position half the time, queries mixed in
   function automatic void queue_frames(input int frames, input int queries_per_frame);
      for (int i = 0; i < frames * FRAME_BYTES; i++) begin
         if ($urandom_range(1) == 0) begin
            queue_feed(stream_shadow[stream_pos]);
         end else begin
            queue_feed(DATA_W'($urandom));
         end
         // one query mid-run waits for every response first
         if (i == frames * FRAME_BYTES / 2) begin
            queue_random_query(1'b1);
         end else if ($urandom_range(FRAME_BYTES - 1) < queries_per_frame) begin
            queue_random_query(1'b0);
         end
      end
   endfunction

   // wait until the block has drained, then let a feed in flight finish
   task automatic settle_block();
      while (request_queue.size() != 0 || req_bus.valid || predicted_replies.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] index,
                                input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_written++;
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_BUCKET_FRAMES;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_FEED;
      req_bus.data_byte    = '0;
      req_bus.query_bucket = '0;
      req_bus.query_column = '0;
      rsp_bus.ready        = 1'b0;
      send_idle_pct        = 35;
      recv_idle_pct        = 69;
      fail_count           = 0;
      feeds_taken          = 0;
      replies_checked      = 0;
      settings_written     = 0;
      idle_cycles          = 0;
      stream_pos           = 0;
      for (int i = 0; i < FRAME_BYTES; i++) stream_shadow[i] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: field extremes, out-of-range cells, first stream bytes
      queue_query(0, 0, 1'b0);
      queue_query(BUCKETS - 1, FRAME_BYTES - 1, 1'b0);
      queue_query(31, 31, 1'b0);
      queue_query(BUCKETS, 0, 1'b0);
      queue_query(0, FRAME_BYTES, 1'b0);
      queue_feed(8'h00);
      queue_feed(8'hFF);
      queue_feed(8'hA5);
      queue_feed(8'h5A);
      queue_query(0, 0, 1'b1);
      settle_block();

      // short buckets so that cold, warm and hot are all reachable
      write_setting(CSR_BUCKET_FRAMES, 16'd3);
      write_setting(CSR_WARM_FROM, 16'd1);
      write_setting(CSR_HOT_FROM, 16'd2);
      queue_frames(4, 1);
      settle_block();

      // sender now slower; zero bucket length, reversed thresholds, run until full
      send_idle_pct = 69;
      recv_idle_pct = 35;
      write_setting(CSR_BUCKET_FRAMES, 16'd0);
      write_setting(CSR_WARM_FROM, 16'd1);
      write_setting(CSR_HOT_FROM, 16'd0);
      queue_frames(19, 1);
      repeat (4) queue_random_query(1'b0);
      settle_block();

      // no idling; store full, bytes ignored among queries, threshold extremes
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_setting(CSR_BUCKET_FRAMES, 16'hFFFF);
      write_setting(CSR_WARM_FROM, 16'd0);
      write_setting(CSR_HOT_FROM, 16'hFFFF);
      for (int i = 0; i < 24; i++) begin
         if ($urandom_range(4) == 0) begin
            queue_feed(DATA_W'($urandom));
         end else begin
            queue_random_query(1'b0);
         end
      end
      settle_block();

      write_setting(CSR_WARM_FROM, 16'hFFFF);
      write_setting(CSR_HOT_FROM, 16'd0);
      repeat (12) queue_random_query(1'b0);
      settle_block();

      $display("run: %0d stream bytes and %0d checked query responses, store filled to %0d",
               feeds_taken, replies_checked, fill_bucket);
      $display("run: %0d register writes over four settings after reset, %0d mismatches",
               settings_written, fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: byte_change_heatmap.f
+incdir+src
src/bch_pkg.sv
src/bch_req_if.sv
src/bch_rsp_if.sv
src/bch_ram.sv
src/bch_tracker.sv
src/bch_update.sv
src/byte_change_heatmap.sv
src/bch_checker.sv
verif/tb.sv
